// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Default number of entries held
    localparam int DEPTH_DEFAULT = 16;

    // Operation codes carried on the mode field
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    // One stored entry: value and its priority
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    localparam int ENTRY_WIDTH = $bits(entry_t);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_PUT,
        ST_REM_SCAN,
        ST_PEEK
    } state_t;

endpackage : spq_pkg

`default_nettype wire

// ===== rtl/core/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : spq_ram

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Priority queue of up to DEPTH entries kept in ascending priority order in
// one synchronous RAM, maintained by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (mode, item_value, item_priority) is taken at a rising
//   edge where start is high and busy is low. Exactly one result word
//   (status, out_value, out_priority, count) follows, shown for one cycle
//   with done high; the receiver cannot stall it.
// Operation:
//   insert: scans down from the top, shifting each higher-priority entry
//           up one slot; into an empty queue, or when full: no scan.
//   remove: scans up from slot zero and always runs to the top entry;
//           empty: no scan.
//   peek:   reads the top entry; empty, or unused mode: no read.
// Each step of a scan reads one entry and may write one shifted entry
// through the single RAM read port and write port.
// A new command is taken in the cycle in which done is shown.
// Reset clears the entry count and the sequencer; the RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  mode,
    input  wire logic signed [31:0] item_value,
    input  wire logic signed [15:0] item_priority,
    output logic                    done,
    output logic             [1:0]  status,
    output logic signed      [31:0] out_value,
    output logic signed      [15:0] out_priority,
    output logic             [4:0]  count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Control state
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg,  done_next;

    // Working and result registers
    logic [IW-1:0] idx_reg,    idx_next;
    logic          found_reg,  found_next;
    entry_t        item_reg,   item_next;
    entry_t        hit_reg,    hit_next;
    logic [1:0]    status_reg, status_next;
    entry_t        res_reg,    res_next;
    logic [4:0]    cnt_reg,    cnt_next;

    // RAM port signals
    logic          we;
    logic [IW-1:0] waddr;
    entry_t        wdata;
    logic [IW-1:0] raddr;
    logic [ENTRY_WIDTH-1:0] rdata_raw;
    entry_t        rdata;

    logic          accept;
    logic [IW-1:0] top_idx;
    logic          hit_now;

    assign accept  = start && !busy;
    assign top_idx = IW'(count_reg - 1'b1);
    assign rdata   = entry_t'(rdata_raw);
    assign hit_now = (rdata.value == item_reg.value);

    spq_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (1'b1),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    // Hold the control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Hold the working and result words
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        item_reg   <= item_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        cnt_reg    <= cnt_next;
    end

    // Sequence the scans and build each result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        found_next  = found_reg;
        item_next   = item_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        res_next    = res_reg;
        cnt_next    = cnt_reg;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = item_reg;
        raddr       = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next.value = item_value;
                    item_next.prio  = item_priority;
                    found_next      = 1'b0;
                    res_next        = '0;
                    status_next     = STATUS_OK;
                    cnt_next        = 5'(count_reg);
                    case (mode)
                        MODE_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = STATUS_FULL;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                // Empty queue: drop the entry straight into slot zero
                                we          = 1'b1;
                                waddr       = '0;
                                wdata.value = item_value;
                                wdata.prio  = item_priority;
                                count_next  = count_reg + 1'b1;
                                cnt_next    = 5'(count_reg + 1'b1);
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                raddr      = top_idx;
                                idx_next   = top_idx;
                                state_next = ST_INS_SCAN;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                raddr      = '0;
                                idx_next   = '0;
                                state_next = ST_REM_SCAN;
                            end
                        end
                        MODE_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                raddr      = top_idx;
                                state_next = ST_PEEK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_INS_SCAN:
            begin
                if (rdata.prio > item_reg.prio)
                begin
                    // Shift the higher entry up one slot
                    we    = 1'b1;
                    waddr = idx_reg + 1'b1;
                    wdata = rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        raddr    = idx_reg - 1'b1;
                        idx_next = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    // Place the new entry above this one
                    we          = 1'b1;
                    waddr       = idx_reg + 1'b1;
                    wdata       = item_reg;
                    count_next  = count_reg + 1'b1;
                    cnt_next    = 5'(count_reg + 1'b1);
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_INS_PUT:
            begin
                // Every entry was higher: place the new entry at the bottom
                we         = 1'b1;
                waddr      = '0;
                wdata      = item_reg;
                count_next = count_reg + 1'b1;
                cnt_next   = 5'(count_reg + 1'b1);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_REM_SCAN:
            begin
                if (found_reg)
                begin
                    // Close the gap left by the removed entry
                    we    = 1'b1;
                    waddr = idx_reg - 1'b1;
                    wdata = rdata;
                end
                else if (hit_now)
                begin
                    found_next = 1'b1;
                    hit_next   = rdata;
                end
                if (idx_reg == top_idx)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (found_reg)
                    begin
                        res_next   = hit_reg;
                        count_next = count_reg - 1'b1;
                        cnt_next   = 5'(count_reg - 1'b1);
                    end
                    else if (hit_now)
                    begin
                        res_next   = rdata;
                        count_next = count_reg - 1'b1;
                        cnt_next   = 5'(count_reg - 1'b1);
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                else
                begin
                    raddr    = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_PEEK:
            begin
                res_next   = rdata;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_value    = res_reg.value;
    assign out_priority = res_reg.prio;
    assign count        = cnt_reg;

endmodule : sorted_priority_queue_core

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue core. Command words go in
// through the start/busy handshake with random gaps; a shadow copy of the
// queue predicts each result word, and every done strobe is checked against
// the oldest prediction. Directed corner cases come first, then fill/drain
// sweeps and a long mixed random run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int QDEPTH = DEPTH_DEFAULT;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = QDEPTH + 8;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic signed [15:0] prio;
        logic [4:0]         count;
    } result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         mode = MODE_INSERT;
    logic signed [31:0] item_value = '0;
    logic signed [15:0] item_priority = '0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic signed [15:0] out_priority;
    logic [4:0]         count;

    // Shadow copy of the queue contents, kept in ascending priority order
    logic signed [31:0] shadow_value [QDEPTH];
    logic signed [15:0] shadow_prio [QDEPTH];
    int                 shadow_count = 0;

    result_t            pending_results [$];
    int                 mismatch_count = 0;
    int                 idle_pct = 30;
    int                 mode_hits [4] = '{0, 0, 0, 0};
    int                 status_hits [4] = '{0, 0, 0, 0};

    sorted_priority_queue_core #(.DEPTH(QDEPTH)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .item_value   (item_value),
        .item_priority(item_priority),
        .done         (done),
        .status       (status),
        .out_value    (out_value),
        .out_priority (out_priority),
        .count        (count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Count a failure; report only the first few in full
    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Apply one accepted command word to the shadow queue and queue its result
    task automatic shadow_apply(input logic [1:0] m, input logic signed [31:0] v,
                                input logic signed [15:0] p);
        result_t r;
        int      pos;
        int      j;
        r.status = STATUS_OK;
        r.value  = '0;
        r.prio   = '0;
        case (m)
            MODE_INSERT:
            begin
                if (shadow_count >= QDEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    // land after every entry of equal or lower priority
                    pos = 0;
                    while (pos < shadow_count && shadow_prio[pos] <= p)
                        pos++;
                    for (j = shadow_count; j > pos; j--)
                    begin
                        shadow_value[j] = shadow_value[j - 1];
                        shadow_prio[j]  = shadow_prio[j - 1];
                    end
                    shadow_value[pos] = v;
                    shadow_prio[pos]  = p;
                    shadow_count++;
                end
            end
            MODE_REMOVE:
            begin
                if (shadow_count == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    pos = 0;
                    while (pos < shadow_count && shadow_value[pos] != v)
                        pos++;
                    if (pos >= shadow_count)
                        r.status = STATUS_NOT_FOUND;
                    else
                    begin
                        r.value = shadow_value[pos];
                        r.prio  = shadow_prio[pos];
                        for (j = pos; j + 1 < shadow_count; j++)
                        begin
                            shadow_value[j] = shadow_value[j + 1];
                            shadow_prio[j]  = shadow_prio[j + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            MODE_PEEK:
            begin
                if (shadow_count == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    r.value = shadow_value[shadow_count - 1];
                    r.prio  = shadow_prio[shadow_count - 1];
                end
            end
            default:
            begin
                // unused mode: answer ok and leave the queue alone
            end
        endcase
        r.count = 5'(shadow_count);
        mode_hits[m]++;
        status_hits[r.status]++;
        pending_results.push_back(r);
    endtask

    // Present one command word and hold it until the core takes it
    task automatic send_word(input logic [1:0] m, input logic signed [31:0] v,
                             input logic signed [15:0] p);
        start         <= 1'b1;
        mode          <= m;
        item_value    <= v;
        item_priority <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow_apply(m, v, p);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    endtask

    // Values: a small pool for duplicates, the extremes, or anything
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3, 4: return 32'($urandom_range(0, 7)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    // Priorities: clustered for ties, the extremes, or anything
    function automatic logic signed [15:0] pick_prio();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3, 4: return 16'($urandom_range(0, 6)) - 16'sd3;
            default: return 16'($urandom);
        endcase
    endfunction

    // Build and send one random word; fill_pct weights inserts
    task automatic send_random_word(input int fill_pct);
        int                 roll;
        logic signed [31:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            send_word(MODE_UNUSED, $urandom, 16'($urandom));
        else if ($urandom_range(0, 99) < fill_pct)
            send_word(MODE_INSERT, pick_value(), pick_prio());
        else if ($urandom_range(0, 99) < 70)
        begin
            // mostly remove something that is held, so the queue drains
            if (shadow_count > 0 && $urandom_range(0, 99) < 75)
                v = shadow_value[$urandom_range(0, shadow_count - 1)];
            else
                v = pick_value();
            send_word(MODE_REMOVE, v, 16'($urandom));
        end
        else
            send_word(MODE_PEEK, $urandom, 16'($urandom));
    endtask

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                note_mismatch($sformatf("result with nothing expected: st=%0d val=%0d pri=%0d cnt=%0d",
                                        status, out_value, out_priority, count));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || out_value !== want.value ||
                    out_priority !== want.prio || count !== want.count)
                    note_mismatch($sformatf(
                        "exp st=%0d val=%0d pri=%0d cnt=%0d, got st=%0d val=%0d pri=%0d cnt=%0d",
                        want.status, want.value, want.prio, want.count,
                        status, out_value, out_priority, count));
            end
        end
    end

    // Corner cases: empty queue, extreme fields, ties, misses, unused mode, full
    task automatic test_directed_cases();
        send_word(MODE_PEEK, 32'sd0, 16'sd0);
        send_word(MODE_REMOVE, 32'sd5, 16'sd0);
        send_word(MODE_UNUSED, 32'shffffffff, 16'shffff);
        send_word(MODE_INSERT, 32'sh7fffffff, 16'sh7fff);
        send_word(MODE_INSERT, 32'sh80000000, 16'sh8000);
        send_word(MODE_INSERT, 32'sd0, 16'sd0);
        send_word(MODE_INSERT, -32'sd1, 16'sd0);
        send_word(MODE_PEEK, 32'sd0, 16'sh7fff);
        send_word(MODE_REMOVE, 32'sd12345, 16'sd0);
        send_word(MODE_REMOVE, 32'sd0, 16'sh8000);
        send_word(MODE_UNUSED, 32'sd0, 16'sd0);
        // top up to full with ties and extremes mixed in, then overflow
        while (shadow_count < QDEPTH)
            send_word(MODE_INSERT, pick_value(), pick_prio());
        send_word(MODE_INSERT, 32'sh55555555, 16'sh5555);
        send_word(MODE_PEEK, 32'shaaaaaaaa, 16'shaaaa);
    endtask

    // Swing between full and empty repeatedly with no idling at all
    task automatic test_fill_drain_sweeps(input int words);
        bit filling;
        filling  = 1'b0;
        idle_pct = 0;
        repeat (words)
        begin
            if (filling && shadow_count == QDEPTH && $urandom_range(0, 99) < 30)
                filling = 1'b0;
            else if (!filling && shadow_count == 0 && $urandom_range(0, 99) < 30)
                filling = 1'b1;
            send_random_word(filling ? 85 : 12);
        end
        idle_pct = 30;
    endtask

    // Mixed traffic with the insert weighting changed every hundred words
    task automatic test_random_mix(input int words);
        int fill_pct;
        fill_pct = 50;
        for (int n = 0; n < words; n++)
        begin
            if (n % 100 == 0)
                fill_pct = $urandom_range(20, 80);
            send_random_word(fill_pct);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fill_drain_sweeps(600);
        test_random_mix(1200);

        // drain outstanding results, then let the core settle
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            note_mismatch("expected results left over");
        if (mismatch_count > REPORT_LIMIT)
            $display("%0d further mismatches not shown", mismatch_count - REPORT_LIMIT);
        $display("Ran %0d inserts, %0d removes, %0d peeks, %0d unused-mode words.",
                 mode_hits[MODE_INSERT], mode_hits[MODE_REMOVE], mode_hits[MODE_PEEK],
                 mode_hits[MODE_UNUSED]);
        $display("Outcomes: %0d ok, %0d full, %0d empty, %0d not found; %0d mismatches.",
                 status_hits[STATUS_OK], status_hits[STATUS_FULL],
                 status_hits[STATUS_EMPTY], status_hits[STATUS_NOT_FOUND], mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #20_000_000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule : tb_top
